### rtl/owdm_pkg.sv
package owdm_pkg;

   // datapath widths
   localparam int VEL_W      = 16;
   localparam int DRV_W      = 18;
   localparam int MAG_W      = 17;
   localparam int LIM_W      = 15;
   localparam int NUM_W      = MAG_W + LIM_W;
   localparam int QUO_W      = 15;
   localparam int COEF_W     = 30;
   localparam int PROD_W     = VEL_W + 1 + COEF_W - 1;
   localparam int DIV_STEPS  = 3;
   localparam int DIV_STAGES = QUO_W / DIV_STEPS;
   localparam int LANES      = 3;

   // velocity scaling: 1.35 in Q8.8, capped at 135
   localparam logic [VEL_W-1:0] VEL_CAP    = 16'd34560;
   localparam logic [VEL_W-1:0] VEL_WHOLE  = 16'd345;
   localparam logic [9:0]       FRAC_MUL   = 10'd6;
   localparam logic [9:0]       FRAC_BIAS  = 10'd5;
   localparam logic [17:0]      RECIP_TEN  = 18'd205;
   localparam logic [34:0]      RECIP_FIVE = 35'd209716;

   // mix coefficients, Q1.14
   localparam int COEF_MAIN  = 9476;
   localparam int COEF_CROSS = 5461;
   localparam int COEF_SIDE  = 10922;

   localparam logic signed [PROD_W-1:0] ROUND_HALF = 46'sd134217728;

   // reset values of the control registers
   localparam logic [7:0] RST_HEADING_GAIN = 8'd51;
   localparam logic [6:0] RST_TURN_LIMIT   = 7'd10;
   localparam logic [6:0] RST_DRIVE_LIMIT  = 7'd100;
   localparam logic [7:0] RST_STOP_MAIN    = 8'd20;
   localparam logic [7:0] RST_STOP_SIDE    = 8'd15;
   localparam logic [7:0] RST_SLOW_RANGE   = 8'd25;
   localparam logic [9:0] RST_LINE_LEVEL   = 10'd20;

   typedef enum logic [2:0] {
      CSR_HEADING_GAIN,
      CSR_TURN_LIMIT,
      CSR_DRIVE_LIMIT,
      CSR_STOP_MAIN,
      CSR_STOP_SIDE,
      CSR_SLOW_RANGE,
      CSR_LINE_LEVEL
   } csr_index_type;

   typedef enum logic [1:0] {
      SLOW_NONE,
      SLOW_HALF,
      SLOW_SIXTY,
      SLOW_STOP
   } slow_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] a1;
      logic signed [COEF_W-1:0] a2;
      logic signed [COEF_W-1:0] a3;
   } coef_type;

   typedef struct packed {
      logic [MAG_W-1:0] rem;
      logic [QUO_W-1:0] nq;
   } div_lane_type;

   typedef struct packed {
      div_lane_type [LANES-1:0]          lane;
      logic [MAG_W-1:0]                  divisor;
      logic [LANES-1:0]                  neg;
      logic [LANES-1:0][DRV_W-1:0]       drv;
      logic                              scale;
      logic                              stop;
   } div_beat_type;

   // sine in Q1.14 over twelve sectors of 30 degrees
   function automatic int sin_q14(input logic [3:0] k);
      int s;
      case (k)
         4'd0:    s = 0;
         4'd1:    s = 8192;
         4'd2:    s = 14189;
         4'd3:    s = 16384;
         4'd4:    s = 14189;
         4'd5:    s = 8192;
         4'd6:    s = 0;
         4'd7:    s = -8192;
         4'd8:    s = -14189;
         4'd9:    s = -16384;
         4'd10:   s = -14189;
         4'd11:   s = -8192;
         default: s = 0;
      endcase
      return s;
   endfunction

   // per-sector wheel coefficients, sine and cosine folded in
   function automatic coef_type mix_coef(input logic [3:0] dir);
      coef_type   c;
      logic [3:0] k;
      logic [3:0] kc;
      int         sv;
      int         cv;
      k  = (dir >= 4'd12) ? dir - 4'd12 : dir;
      kc = (k >= 4'd9) ? k - 4'd9 : k + 4'd3;
      sv = sin_q14(k);
      cv = sin_q14(kc);
      c.a1 = COEF_W'(COEF_MAIN * cv - COEF_CROSS * sv);
      c.a2 = COEF_W'(-COEF_MAIN * cv - COEF_CROSS * sv);
      c.a3 = COEF_W'(COEF_SIDE * sv);
      return c;
   endfunction

   // a few restoring division steps on every lane
   function automatic div_beat_type div_step(input div_beat_type b);
      div_beat_type r;
      logic [MAG_W:0] t;
      logic           qb;
      r = b;
      for (int l = 0; l < LANES; l++) begin
         for (int s = 0; s < DIV_STEPS; s++) begin
            t  = {r.lane[l].rem, r.lane[l].nq[QUO_W-1]};
            qb = (t >= {1'b0, r.divisor});
            r.lane[l].rem = qb ? MAG_W'(t - {1'b0, r.divisor}) : t[MAG_W-1:0];
            r.lane[l].nq  = {r.lane[l].nq[QUO_W-2:0], qb};
         end
      end
      return r;
   endfunction

endpackage

### rtl/omni_wheel_drive_mixer_unit.sv
// channel  | direction | handshake              | beat
// req_     | in        | req_valid / req_ready  | one drive command
// rsp_     | out       | rsp_valid / rsp_ready  | three wheel drives and align flag
// csr_     | in        | csr_write_enable       | one register write, no wait
//
// one command enters per cycle unless rsp_ready stalls the pipe; each command passes
// through six arithmetic stages, five divider stages and the output register
// the final scale-down is a pipelined restoring divider, three quotient bits per stage
// synchronous active-high reset empties every stage and loads register defaults
// a stall at rsp_ready fills empty stages first, then backs up to req_ready
module omni_wheel_drive_mixer_unit import owdm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [3:0]          req_direction,
   input  logic [6:0]          req_speed,
   input  logic signed [8:0]   req_heading,
   input  logic [7:0]          req_range_s0,
   input  logic [7:0]          req_range_s1,
   input  logic [7:0]          req_range_s2,
   input  logic [7:0]          req_range_s3,
   input  logic [9:0]          req_line_level,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [15:0]  rsp_wheel_one,
   output logic signed [15:0]  rsp_wheel_two,
   output logic signed [15:0]  rsp_wheel_three,
   output logic                rsp_align_request,
   input  logic                csr_write_enable,
   input  logic [2:0]          csr_index,
   input  logic [9:0]          csr_write_data
);

   // control registers
   logic [7:0] gain_ff;
   logic [6:0] turn_ff;
   logic [6:0] dlim_ff;
   logic [7:0] stop_main_ff;
   logic [7:0] stop_side_ff;
   logic [7:0] slow_rng_ff;
   logic [9:0] line_lvl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= RST_HEADING_GAIN;
         turn_ff      <= RST_TURN_LIMIT;
         dlim_ff      <= RST_DRIVE_LIMIT;
         stop_main_ff <= RST_STOP_MAIN;
         stop_side_ff <= RST_STOP_SIDE;
         slow_rng_ff  <= RST_SLOW_RANGE;
         line_lvl_ff  <= RST_LINE_LEVEL;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_HEADING_GAIN: gain_ff      <= csr_write_data[7:0];
            CSR_TURN_LIMIT:   turn_ff      <= csr_write_data[6:0];
            CSR_DRIVE_LIMIT:  dlim_ff      <= csr_write_data[6:0];
            CSR_STOP_MAIN:    stop_main_ff <= csr_write_data[7:0];
            CSR_STOP_SIDE:    stop_side_ff <= csr_write_data[7:0];
            CSR_SLOW_RANGE:   slow_rng_ff  <= csr_write_data[7:0];
            CSR_LINE_LEVEL:   line_lvl_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // pipeline valids and load chain
   logic [5:0] vld_ff;
   logic [5:0] load;
   logic       div_in_ready;
   logic       div_out_valid;
   logic       div_out_ready;

   always_comb begin
      load[5] = !vld_ff[5] || div_in_ready;
      for (int s = 4; s >= 0; s--) begin
         load[s] = !vld_ff[s] || load[s+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (load[0]) vld_ff[0] <= req_valid;
         for (int s = 1; s < 6; s++) begin
            if (load[s]) vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   assign req_ready = load[0];

   // stage 1: speed scale, range rules, raw turn term
   logic [9:0]             frac_arg;
   logic [17:0]            frac_prod;
   logic [VEL_W-1:0]       v_raw;
   logic [VEL_W-1:0]       v1_in;
   slow_type               slow1_in;
   logic signed [DRV_W-1:0] wz1_in;
   logic [VEL_W-1:0]       v1_ff;
   slow_type               slow1_ff;
   logic signed [DRV_W-1:0] wz1_ff;
   logic [3:0]             dir1_ff;

   always_comb begin
      frac_arg  = {3'b0, req_speed} * FRAC_MUL + FRAC_BIAS;
      frac_prod = {8'b0, frac_arg} * RECIP_TEN;
      v_raw     = {9'b0, req_speed} * VEL_WHOLE + {9'b0, frac_prod[17:11]};
      v1_in     = (v_raw > VEL_CAP) ? VEL_CAP : v_raw;
      wz1_in    = $signed({1'b0, gain_ff}) * req_heading;
      slow1_in  = SLOW_NONE;
      case (req_direction)
         4'd0: begin
            if (req_line_level < line_lvl_ff && req_range_s0 < slow_rng_ff) slow1_in = SLOW_HALF;
         end
         4'd1, 4'd2: begin
            if (req_range_s0 < stop_main_ff || req_range_s1 < stop_side_ff) slow1_in = SLOW_STOP;
            else if (req_range_s0 < slow_rng_ff || req_range_s1 < slow_rng_ff)
               slow1_in = SLOW_SIXTY;
         end
         4'd3: begin
            if (req_range_s1 < stop_side_ff) slow1_in = SLOW_STOP;
            else if (req_range_s1 < slow_rng_ff) slow1_in = SLOW_HALF;
         end
         4'd4, 4'd5: begin
            if (req_range_s1 < stop_side_ff || req_range_s2 < stop_main_ff) slow1_in = SLOW_STOP;
            else if (req_range_s1 < slow_rng_ff || req_range_s2 < slow_rng_ff)
               slow1_in = SLOW_SIXTY;
         end
         4'd6: begin
            if (req_range_s2 < stop_main_ff) slow1_in = SLOW_STOP;
            else if (req_range_s2 < slow_rng_ff) slow1_in = SLOW_HALF;
         end
         4'd7, 4'd8: begin
            if (req_range_s2 < stop_main_ff || req_range_s3 < stop_side_ff) slow1_in = SLOW_STOP;
            else if (req_range_s2 < slow_rng_ff || req_range_s3 < slow_rng_ff)
               slow1_in = SLOW_SIXTY;
         end
         4'd9: begin
            if (req_range_s3 < stop_side_ff) slow1_in = SLOW_STOP;
            else if (req_range_s3 < slow_rng_ff) slow1_in = SLOW_HALF;
         end
         4'd10, 4'd11: begin
            if (req_range_s0 < stop_main_ff || req_range_s3 < stop_side_ff) slow1_in = SLOW_STOP;
            else if (req_range_s0 < slow_rng_ff || req_range_s3 < slow_rng_ff)
               slow1_in = SLOW_SIXTY;
         end
         default: slow1_in = SLOW_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         v1_ff    <= v1_in;
         slow1_ff <= slow1_in;
         wz1_ff   <= wz1_in;
         dir1_ff  <= req_direction;
      end
   end

   // stage 2: apply slow-down, clamp turn term
   logic [16:0]            v_x3;
   logic [34:0]            sixty_prod;
   logic [VEL_W-1:0]       v2_in;
   logic [LIM_W-1:0]       turn_lim;
   logic signed [DRV_W-1:0] tl_pos;
   logic signed [DRV_W-1:0] wz2_in;
   logic [VEL_W-1:0]       v2_ff;
   logic signed [DRV_W-1:0] wz2_ff;
   logic [3:0]             dir2_ff;

   always_comb begin
      v_x3       = {1'b0, v1_ff} * 17'd3;
      sixty_prod = {18'b0, v_x3} * RECIP_FIVE;
      case (slow1_ff)
         SLOW_STOP:  v2_in = '0;
         SLOW_SIXTY: v2_in = {1'b0, sixty_prod[34:20]};
         SLOW_HALF:  v2_in = {1'b0, v1_ff[VEL_W-1:1]};
         default:    v2_in = v1_ff;
      endcase
      turn_lim = {turn_ff, 8'b0};
      tl_pos   = $signed({3'b0, turn_lim});
      if (wz1_ff > tl_pos) wz2_in = tl_pos;
      else if (wz1_ff < -tl_pos) wz2_in = -tl_pos;
      else wz2_in = wz1_ff;
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         v2_ff   <= v2_in;
         wz2_ff  <= wz2_in;
         dir2_ff <= dir1_ff;
      end
   end

   // stage 3: move vector times wheel coefficients
   coef_type                 coef3;
   logic signed [PROD_W-1:0] p3_in [LANES];
   logic signed [PROD_W-1:0] p3_ff [LANES];
   logic signed [DRV_W-1:0]  wz3_ff;
   logic                     stop3_ff;

   always_comb begin
      coef3    = mix_coef(dir2_ff);
      p3_in[0] = $signed({1'b0, v2_ff}) * coef3.a1;
      p3_in[1] = $signed({1'b0, v2_ff}) * coef3.a2;
      p3_in[2] = $signed({1'b0, v2_ff}) * coef3.a3;
   end

   always_ff @(posedge clock) begin
      if (load[2]) begin
         p3_ff    <= p3_in;
         wz3_ff   <= wz2_ff;
         stop3_ff <= (v2_ff == '0);
      end
   end

   // stage 4: round to Q8 and add turn term
   logic signed [PROD_W-1:0] p_rnd [LANES];
   logic signed [DRV_W-1:0]  f4_in [LANES];
   logic signed [DRV_W-1:0]  f4_ff [LANES];
   logic                     stop4_ff;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         p_rnd[l] = p3_ff[l] + ROUND_HALF;
         f4_in[l] = $signed(p_rnd[l][28 +: DRV_W]) + wz3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load[3]) begin
         f4_ff    <= f4_in;
         stop4_ff <= stop3_ff;
      end
   end

   // stage 5: magnitudes and largest one
   logic [MAG_W-1:0]        mag5_in [LANES];
   logic [MAG_W-1:0]        max5_in;
   logic [MAG_W-1:0]        mag5_ff [LANES];
   logic [MAG_W-1:0]        max5_ff;
   logic signed [DRV_W-1:0] f5_ff [LANES];
   logic                    stop5_ff;

   always_comb begin
      max5_in = '0;
      for (int l = 0; l < LANES; l++) begin
         mag5_in[l] = f4_ff[l][DRV_W-1] ? MAG_W'(-f4_ff[l]) : f4_ff[l][MAG_W-1:0];
         if (mag5_in[l] > max5_in) max5_in = mag5_in[l];
      end
   end

   always_ff @(posedge clock) begin
      if (load[4]) begin
         mag5_ff  <= mag5_in;
         max5_ff  <= max5_in;
         f5_ff    <= f4_ff;
         stop5_ff <= stop4_ff;
      end
   end

   // stage 6: limit compare and dividends
   logic [LIM_W-1:0]  drive_lim;
   logic [NUM_W-1:0]  num6 [LANES];
   div_beat_type      beat6_in;
   div_beat_type      beat6_ff;

   always_comb begin
      drive_lim        = {dlim_ff, 8'b0};
      beat6_in.divisor = max5_ff;
      beat6_in.scale   = (max5_ff > {2'b0, drive_lim});
      beat6_in.stop    = stop5_ff;
      for (int l = 0; l < LANES; l++) begin
         num6[l]                 = {{LIM_W{1'b0}}, mag5_ff[l]} * {{MAG_W{1'b0}}, drive_lim};
         beat6_in.lane[l].rem    = num6[l][NUM_W-1:QUO_W];
         beat6_in.lane[l].nq     = num6[l][QUO_W-1:0];
         beat6_in.neg[l]         = f5_ff[l][DRV_W-1];
         beat6_in.drv[l]         = f5_ff[l];
      end
   end

   always_ff @(posedge clock) begin
      if (load[5]) begin
         beat6_ff <= beat6_in;
      end
   end

   // proportional scale-down
   div_beat_type div_out;

   owdm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_ff[5]),
      .in_ready  (div_in_ready),
      .in_beat   (beat6_ff),
      .out_valid (div_out_valid),
      .out_ready (div_out_ready),
      .out_beat  (div_out)
   );

   // output register
   logic              rsp_valid_ff;
   logic [15:0]       wheel_in [LANES];
   logic [15:0]       wheel_ff [LANES];
   logic              align_ff;

   assign div_out_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         if (div_out.stop) wheel_in[l] = '0;
         else if (div_out.scale)
            wheel_in[l] = div_out.neg[l] ? 16'(-{1'b0, div_out.lane[l].nq})
                                         : {1'b0, div_out.lane[l].nq};
         else wheel_in[l] = div_out.drv[l][15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (div_out_ready) begin
         rsp_valid_ff <= div_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (div_out_ready) begin
         wheel_ff <= wheel_in;
         align_ff <= div_out.stop;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_wheel_one     = $signed(wheel_ff[0]);
   assign rsp_wheel_two     = $signed(wheel_ff[2]);
   assign rsp_wheel_three   = $signed(wheel_ff[1]);
   assign rsp_align_request = align_ff;

`ifndef SYNTH
   logic [15:0] chk_mag_one;
   logic [15:0] chk_mag_two;
   logic [15:0] chk_mag_three;
   assign chk_mag_one   = wheel_ff[0][15] ? 16'(-wheel_ff[0]) : wheel_ff[0];
   assign chk_mag_two   = wheel_ff[2][15] ? 16'(-wheel_ff[2]) : wheel_ff[2];
   assign chk_mag_three = wheel_ff[1][15] ? 16'(-wheel_ff[1]) : wheel_ff[1];

   // a stopped move drives all wheels at zero
   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && align_ff |->
         wheel_ff[0] == '0 && wheel_ff[1] == '0 && wheel_ff[2] == '0)
      else $error("align result with nonzero wheel drive");

   // no wheel exceeds the drive limit
   a_drive_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !align_ff |->
         chk_mag_one <= {1'b0, dlim_ff, 8'b0} && chk_mag_two <= {1'b0, dlim_ff, 8'b0} &&
         chk_mag_three <= {1'b0, dlim_ff, 8'b0})
      else $error("wheel drive above drive limit");

   // a held first stage keeps its beat
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] && !load[0] |=> vld_ff[0] && $stable(v1_ff) && $stable(dir1_ff))
      else $error("first stage lost a stalled beat");
`endif

endmodule

### rtl/owdm_div.sv
module owdm_div import owdm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  div_beat_type in_beat,
   output logic         out_valid,
   input  logic         out_ready,
   output div_beat_type out_beat
);

   logic [DIV_STAGES-1:0] vld_ff;
   logic [DIV_STAGES-1:0] vld_in;
   logic [DIV_STAGES-1:0] load;
   div_beat_type          beat_ff [DIV_STAGES];
   div_beat_type          beat_in [DIV_STAGES];

   // stage loads when empty or when its successor moves
   always_comb begin
      load[DIV_STAGES-1] = !vld_ff[DIV_STAGES-1] || out_ready;
      for (int s = DIV_STAGES - 2; s >= 0; s--) begin
         load[s] = !vld_ff[s] || load[s+1];
      end
   end

   // each stage retires a few quotient bits
   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      if (s == 0) begin : g_first
         assign beat_in[s] = div_step(in_beat);
         assign vld_in[s]  = in_valid;
      end else begin : g_next
         assign beat_in[s] = div_step(beat_ff[s-1]);
         assign vld_in[s]  = vld_ff[s-1];
      end

      always_ff @(posedge clock) begin
         if (load[s]) begin
            beat_ff[s] <= beat_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            if (load[s]) begin
               vld_ff[s] <= vld_in[s];
            end
         end
      end
   end

   assign in_ready  = load[0];
   assign out_valid = vld_ff[DIV_STAGES-1];
   assign out_beat  = beat_ff[DIV_STAGES-1];

endmodule

### test/omni_wheel_drive_mixer_unit_tb.sv
`timescale 1ns / 100ps

module omni_wheel_drive_mixer_unit_tb;
   import owdm_pkg::*;

   typedef struct {
      logic [3:0]        direction;
      logic [6:0]        speed;
      logic signed [8:0] heading;
      logic [7:0]        r0;
      logic [7:0]        r1;
      logic [7:0]        r2;
      logic [7:0]        r3;
      logic [9:0]        line;
   } drive_cmd_type;

   typedef struct {
      logic signed [15:0] w1;
      logic signed [15:0] w2;
      logic signed [15:0] w3;
      logic               align;
   } wheel_set_type;

   localparam longint K_MAIN  = 9476;
   localparam longint K_CROSS = 5461;
   localparam longint K_SIDE  = 10922;
   localparam longint V_CAP   = 135 * 256;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [3:0] req_direction = '0;
   logic [6:0] req_speed = '0;
   logic signed [8:0] req_heading = '0;
   logic [7:0] req_range_s0 = '0;
   logic [7:0] req_range_s1 = '0;
   logic [7:0] req_range_s2 = '0;
   logic [7:0] req_range_s3 = '0;
   logic [9:0] req_line_level = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_wheel_one;
   logic signed [15:0] rsp_wheel_two;
   logic signed [15:0] rsp_wheel_three;
   logic rsp_align_request;
   logic csr_write_enable = 1'b0;
   logic [2:0] csr_index = '0;
   logic [9:0] csr_write_data = '0;

   // shadow copy of the control registers
   logic [7:0] gain_q8 = RST_HEADING_GAIN;
   logic [6:0] turn_lim = RST_TURN_LIMIT;
   logic [6:0] drive_lim = RST_DRIVE_LIMIT;
   logic [7:0] stop_main = RST_STOP_MAIN;
   logic [7:0] stop_side = RST_STOP_SIDE;
   logic [7:0] slow_rng = RST_SLOW_RANGE;
   logic [9:0] line_lvl = RST_LINE_LEVEL;

   int sine_tab[12] = '{0, 8192, 14189, 16384, 14189, 8192,
                        0, -8192, -14189, -16384, -14189, -8192};

   drive_cmd_type cmd_queue[$];
   wheel_set_type wheel_queue[$];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatches = 0;

   omni_wheel_drive_mixer_unit u_dut (.*);

   always #5 clock = ~clock;

   // expected wheel drives for one command
   function automatic wheel_set_type mix_wheels(drive_cmd_type c);
      longint v, p, q, f1, f2, f3, wz, tl, lim, m;
      slow_type sl;
      int k;
      wheel_set_type r;
      sl = SLOW_NONE;
      v = (longint'(c.speed) * 135 * 256 + 50) / 100;
      if (v > V_CAP) v = V_CAP;
      case (c.direction)
         4'd0: if (c.line < line_lvl && c.r0 < slow_rng) sl = SLOW_HALF;
         4'd1, 4'd2: begin
            if (c.r0 < stop_main || c.r1 < stop_side) sl = SLOW_STOP;
            else if (c.r0 < slow_rng || c.r1 < slow_rng) sl = SLOW_SIXTY;
         end
         4'd3: begin
            if (c.r1 < stop_side) sl = SLOW_STOP;
            else if (c.r1 < slow_rng) sl = SLOW_HALF;
         end
         4'd4, 4'd5: begin
            if (c.r1 < stop_side || c.r2 < stop_main) sl = SLOW_STOP;
            else if (c.r1 < slow_rng || c.r2 < slow_rng) sl = SLOW_SIXTY;
         end
         4'd6: begin
            if (c.r2 < stop_main) sl = SLOW_STOP;
            else if (c.r2 < slow_rng) sl = SLOW_HALF;
         end
         4'd7, 4'd8: begin
            if (c.r2 < stop_main || c.r3 < stop_side) sl = SLOW_STOP;
            else if (c.r2 < slow_rng || c.r3 < slow_rng) sl = SLOW_SIXTY;
         end
         4'd9: begin
            if (c.r3 < stop_side) sl = SLOW_STOP;
            else if (c.r3 < slow_rng) sl = SLOW_HALF;
         end
         4'd10, 4'd11: begin
            if (c.r0 < stop_main || c.r3 < stop_side) sl = SLOW_STOP;
            else if (c.r0 < slow_rng || c.r3 < slow_rng) sl = SLOW_SIXTY;
         end
         default: sl = SLOW_NONE;
      endcase
      case (sl)
         SLOW_STOP:  v = 0;
         SLOW_SIXTY: v = v * 3 / 5;
         SLOW_HALF:  v = v / 2;
         default:    v = v;
      endcase
      if (v == 0) begin
         r.w1 = '0;
         r.w2 = '0;
         r.w3 = '0;
         r.align = 1'b1;
         return r;
      end
      k = c.direction % 12;
      p = v * sine_tab[(k + 3) % 12];
      q = v * sine_tab[k];
      wz = longint'(gain_q8) * longint'(c.heading);
      tl = longint'(turn_lim) * 256;
      if (wz > tl) wz = tl;
      if (wz < -tl) wz = -tl;
      // round half up from Q36 to Q8
      f1 = ((K_MAIN * p - K_CROSS * q + 64'sd134217728) >>> 28) + wz;
      f2 = ((-K_MAIN * p - K_CROSS * q + 64'sd134217728) >>> 28) + wz;
      f3 = ((K_SIDE * q + 64'sd134217728) >>> 28) + wz;
      m = (f1 < 0) ? -f1 : f1;
      if ((f2 < 0 ? -f2 : f2) > m) m = (f2 < 0) ? -f2 : f2;
      if ((f3 < 0 ? -f3 : f3) > m) m = (f3 < 0) ? -f3 : f3;
      lim = longint'(drive_lim) * 256;
      if (m > lim) begin
         f1 = f1 * lim / m;
         f2 = f2 * lim / m;
         f3 = f3 * lim / m;
      end
      r.w1 = f1[15:0];
      r.w2 = f3[15:0];
      r.w3 = f2[15:0];
      r.align = 1'b0;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // driver: one command beat per handshake
   always @(posedge clock) begin
      drive_cmd_type c;
      logic free;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         free = !req_valid || req_ready;
         if (req_valid && req_ready) begin
            c.direction = req_direction;
            c.speed = req_speed;
            c.heading = req_heading;
            c.r0 = req_range_s0;
            c.r1 = req_range_s1;
            c.r2 = req_range_s2;
            c.r3 = req_range_s3;
            c.line = req_line_level;
            wheel_queue.push_back(mix_wheels(c));
         end
         if (free) begin
            if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               c = cmd_queue.pop_front();
               req_valid <= 1'b1;
               req_direction <= c.direction;
               req_speed <= c.speed;
               req_heading <= c.heading;
               req_range_s0 <= c.r0;
               req_range_s1 <= c.r1;
               req_range_s2 <= c.r2;
               req_range_s3 <= c.r3;
               req_line_level <= c.line;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each result beat against the oldest prediction
   always @(posedge clock) begin
      wheel_set_type w;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (wheel_queue.size() == 0) begin
               report_mismatch("unexpected beat", 1, 0);
            end else begin
               w = wheel_queue.pop_front();
               if (rsp_wheel_one !== w.w1) report_mismatch("wheel_one", rsp_wheel_one, w.w1);
               if (rsp_wheel_two !== w.w2) report_mismatch("wheel_two", rsp_wheel_two, w.w2);
               if (rsp_wheel_three !== w.w3)
                  report_mismatch("wheel_three", rsp_wheel_three, w.w3);
               if (rsp_align_request !== w.align)
                  report_mismatch("align_request", rsp_align_request, w.align);
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic write_reg(csr_index_type idx, int val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val[9:0];
      case (idx)
         CSR_HEADING_GAIN: gain_q8 <= val[7:0];
         CSR_TURN_LIMIT:   turn_lim <= val[6:0];
         CSR_DRIVE_LIMIT:  drive_lim <= val[6:0];
         CSR_STOP_MAIN:    stop_main <= val[7:0];
         CSR_STOP_SIDE:    stop_side <= val[7:0];
         CSR_SLOW_RANGE:   slow_rng <= val[7:0];
         default:          line_lvl <= val[9:0];
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic write_all(int g, int t, int d, int sm, int ss, int sr, int ll);
      write_reg(CSR_HEADING_GAIN, g);
      write_reg(CSR_TURN_LIMIT, t);
      write_reg(CSR_DRIVE_LIMIT, d);
      write_reg(CSR_STOP_MAIN, sm);
      write_reg(CSR_STOP_SIDE, ss);
      write_reg(CSR_SLOW_RANGE, sr);
      write_reg(CSR_LINE_LEVEL, ll);
   endtask

   task automatic add_cmd(int dir, int spd, int hd, int a, int b, int cc, int d, int ln);
      drive_cmd_type c;
      c.direction = dir[3:0];
      c.speed = spd[6:0];
      c.heading = hd[8:0];
      c.r0 = a[7:0];
      c.r1 = b[7:0];
      c.r2 = cc[7:0];
      c.r3 = d[7:0];
      c.line = ln[9:0];
      cmd_queue.push_back(c);
   endtask

   // random command, biased toward range thresholds and legal sectors
   task automatic add_random_cmd();
      int dir, spd, hd, roll;
      int rg[4];
      roll = $urandom_range(99);
      dir = (roll < 90) ? $urandom_range(11) : $urandom_range(15, 12);
      roll = $urandom_range(99);
      if (roll < 8) spd = 0;
      else if (roll < 18) spd = $urandom_range(127, 101);
      else spd = $urandom_range(100, 1);
      roll = $urandom_range(99);
      if (roll < 80) hd = int'($urandom_range(360)) - 180;
      else hd = int'($urandom_range(511)) - 256;
      foreach (rg[i]) begin
         roll = $urandom_range(99);
         if (roll < 50) rg[i] = $urandom_range(255);
         else if (roll < 85) rg[i] = slow_rng + int'($urandom_range(6)) - 3;
         else rg[i] = stop_main + int'($urandom_range(6)) - 3;
         if (rg[i] < 0) rg[i] = 0;
         if (rg[i] > 255) rg[i] = 255;
      end
      roll = $urandom_range(99);
      add_cmd(dir, spd, hd, rg[0], rg[1], rg[2], rg[3],
              (roll < 50) ? $urandom_range(1023) : $urandom_range(line_lvl + 2));
   endtask

   task automatic drain();
      while (cmd_queue.size() > 0 || req_valid || wheel_queue.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // stimulus and phase sequencing
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // directed commands at reset settings
      send_idle_pct = 27;
      recv_idle_pct = 84;
      for (int d = 0; d < 16; d++)
         add_cmd(d, 100, (d * 37) % 361 - 180, 200, 200, 200, 200, 500);
      add_cmd(0, 0, 0, 255, 255, 255, 255, 1023);
      add_cmd(0, 127, -256, 0, 0, 0, 0, 0);
      add_cmd(3, 127, 255, 255, 255, 255, 255, 1023);
      add_cmd(1, 100, 180, 10, 200, 200, 200, 0);
      add_cmd(1, 100, -180, 22, 200, 200, 200, 0);
      add_cmd(6, 50, 0, 255, 255, 22, 255, 0);
      add_cmd(9, 1, 1, 0, 0, 0, 14, 0);
      add_cmd(0, 100, -1, 5, 0, 0, 0, 10);
      drain();
      for (int ph = 0; ph < 9; ph++) begin
         if (ph < 3) begin
            send_idle_pct = 27;
            recv_idle_pct = 84;
         end else if (ph < 6) begin
            send_idle_pct = 84;
            recv_idle_pct = 27;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (ph)
            0: write_all(255, 127, 127, 255, 255, 255, 1023);
            1: write_all(0, 0, 0, 0, 0, 0, 0);
            2: write_all(255, 100, 1, 20, 15, 25, 20);
            default: write_all($urandom_range(255), $urandom_range(127),
                               $urandom_range(127, 1), $urandom_range(60),
                               $urandom_range(60), $urandom_range(90),
                               $urandom_range(1023));
         endcase
         for (int i = 0; i < 61; i++) add_random_cmd();
         drain();
      end
      if (mismatches == 0) begin
         $display("omni_wheel_drive_mixer_unit regression: pass");
      end else begin
         $display("omni_wheel_drive_mixer_unit regression: fail");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("omni_wheel_drive_mixer_unit regression: fail");
      $finish;
   end

endmodule

### files.f
rtl/owdm_pkg.sv
rtl/owdm_div.sv
rtl/omni_wheel_drive_mixer_unit.sv
test/omni_wheel_drive_mixer_unit_tb.sv
